// ----- rtl/scg_pkg.sv -----
`default_nettype none

package scg_pkg;

  // Field widths of the configuration registers and of the result items.
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned COL_W     = 25;
  localparam int unsigned PTR_W     = 28;
  localparam int unsigned VAL_W     = 7;
  localparam int unsigned IMAG_W    = 4;
  localparam int unsigned PROD_W    = 2 * SIZE_W;
  localparam int unsigned CFG_AW    = 5;
  localparam int unsigned CFG_DW    = 32;
  localparam int unsigned SCG_MAX_DIM = 256;

  // Candidate entries of one column, in ascending row order.
  localparam int unsigned SLOTS  = 14;
  localparam int unsigned SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SLOT_DIAG = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_EAST = 4'd1;
  localparam logic [IMAG_W-1:0] IMAG_CPLX = 4'd8;

  typedef enum logic [2:0] {
    MODE_1D  = 3'd0,
    MODE_2D  = 3'd1,
    MODE_3D  = 3'd2,
    MODE_X2D = 3'd3,
    MODE_X3D = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_SIZE_X  = 3'd1,
    REG_SIZE_Y  = 3'd2,
    REG_SIZE_Z  = 3'd3,
    REG_COMPLEX = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SIZE,
    ST_PREP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OFF_NONE,
    OFF_PLUS,
    OFF_MINUS
  } off_t;

  // Register contents and the write strobe, as seen by the datapath.
  typedef struct packed {
    logic [2:0]        mode;
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic              cplx;
    logic              wr;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic size;
    logic prep;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic final_entry;
  } dp_status_t;

  typedef struct packed {
    logic              zsel;
    off_t              ysel;
    off_t              xsel;
    logic signed [VAL_W-1:0] val;
  } slot_t;

  // Row offset and value of each candidate entry.
  function automatic slot_t slot_info(input logic [SLOT_W-1:0] s);
    slot_t r;
    r = '{zsel: 1'b0, ysel: OFF_NONE, xsel: OFF_NONE, val: 7'sd0};
    case (s)
      4'd1:  r = '{1'b0, OFF_NONE,  OFF_PLUS,  -7'sd4};
      4'd2:  r = '{1'b0, OFF_PLUS,  OFF_MINUS, -7'sd2};
      4'd3:  r = '{1'b0, OFF_PLUS,  OFF_NONE,  -7'sd4};
      4'd4:  r = '{1'b0, OFF_PLUS,  OFF_PLUS,  -7'sd2};
      4'd5:  r = '{1'b1, OFF_MINUS, OFF_MINUS, -7'sd1};
      4'd6:  r = '{1'b1, OFF_MINUS, OFF_NONE,  -7'sd2};
      4'd7:  r = '{1'b1, OFF_MINUS, OFF_PLUS,  -7'sd1};
      4'd8:  r = '{1'b1, OFF_NONE,  OFF_MINUS, -7'sd2};
      4'd9:  r = '{1'b1, OFF_NONE,  OFF_NONE,  -7'sd4};
      4'd10: r = '{1'b1, OFF_NONE,  OFF_PLUS,  -7'sd2};
      4'd11: r = '{1'b1, OFF_PLUS,  OFF_MINUS, -7'sd1};
      4'd12: r = '{1'b1, OFF_PLUS,  OFF_NONE,  -7'sd2};
      4'd13: r = '{1'b1, OFF_PLUS,  OFF_PLUS,  -7'sd1};
      default: r = '{1'b0, OFF_NONE, OFF_NONE, 7'sd0};
    endcase
    return r;
  endfunction

  // Diagonal value in quarters from the mode and the boundary flags.
  function automatic logic signed [VAL_W-1:0] diag_value(input mode_t m, input logic bx,
                                                         input logic by, input logic bz);
    logic [1:0]       nb;
    logic [VAL_W-1:0] r;
    nb = 2'({1'b0, bx}) + 2'({1'b0, by}) + 2'({1'b0, bz});
    case (m)
      MODE_2D:  r = 7'd16 - 7'({nb, 2'b00});
      MODE_3D:  r = 7'd24 - 7'({nb, 2'b00});
      MODE_X2D: r = (bx && by) ? 7'd10 : ((bx || by) ? 7'd16 : 7'd24);
      MODE_X3D: begin
        case (nb)
          2'd0:    r = 7'd56;
          2'd1:    r = 7'd40;
          2'd2:    r = 7'd28;
          default: r = 7'd19;
        endcase
      end
      default:  r = bx ? 7'd4 : 7'd8;
    endcase
    return signed'(r);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/scg_in_if.sv -----
`default_nettype none

interface scg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ----- rtl/scg_out_if.sv -----
`default_nettype none

interface scg_out_if import scg_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic [COL_W-1:0]        column_index;
  logic [COL_W-1:0]        row_index;
  logic signed [VAL_W-1:0] value_real;
  logic [IMAG_W-1:0]       value_imag;
  logic [PTR_W-1:0]        column_start;
  logic                    column_done;
  logic                    matrix_done;

  modport source (output valid, output column_index, output row_index, output value_real,
                  output value_imag, output column_start, output column_done,
                  output matrix_done, input ready);
  modport sink (input valid, input column_index, input row_index, input value_real,
                input value_imag, input column_start, input column_done,
                input matrix_done, output ready);
endinterface

`default_nettype wire

// ----- rtl/stencil_laplacian_csc_generator.sv -----
`default_nettype none
// Channel   Dir  Handshake               Payload
// in_ch     in   valid/ready             restart
// out_ch    out  valid/ready             column_index, row_index, value_real,
//                                        value_imag, column_start, column_done,
//                                        matrix_done
// cfg (APB) in   psel/penable/pready     paddr, pwdata, prdata
//
// One item gives a column of n entries (n from 1 to 14): the block takes the
// item, sizes the grid (the nx*ny multiply), prepares the column, then emits one
// entry per cycle from the slot scan while the output register is free.
// The next item is taken while the column's last entry waits in the output register.
// A low out ready holds the scan; the entry order and values do not change.
// rst_n is synchronous, active low; it restores register defaults and column one.

module stencil_laplacian_csc_generator import scg_pkg::*; #(
  parameter int unsigned MAX_DIM = SCG_MAX_DIM
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  scg_in_if.sink                 in_ch,
  scg_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  scg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  scg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  scg_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_restart (in_ch.restart),
    .cmd        (cmd),
    .status     (status),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

// ----- rtl/scg_cfg_regs.sv -----
`default_nettype none

module scg_cfg_regs import scg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  logic [2:0]        mode_r;
  logic [SIZE_W-1:0] size_x_r;
  logic [SIZE_W-1:0] size_y_r;
  logic [SIZE_W-1:0] size_z_r;
  logic              cplx_r;
  logic              wr;
  logic [2:0]        idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[4:2];

  // Register writes in the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_2D;
      size_x_r <= 9'd1;
      size_y_r <= 9'd1;
      size_z_r <= 9'd1;
      cplx_r   <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        REG_MODE:    mode_r   <= pwdata[2:0];
        REG_SIZE_X:  size_x_r <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y:  size_y_r <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z:  size_z_r <= pwdata[SIZE_W-1:0];
        REG_COMPLEX: cplx_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back of the addressed register.
  always_comb begin
    unique case (idx)
      REG_MODE:    prdata = CFG_DW'(mode_r);
      REG_SIZE_X:  prdata = CFG_DW'(size_x_r);
      REG_SIZE_Y:  prdata = CFG_DW'(size_y_r);
      REG_SIZE_Z:  prdata = CFG_DW'(size_z_r);
      REG_COMPLEX: prdata = CFG_DW'(cplx_r);
      default:     prdata = '0;
    endcase
  end

  assign cfg = '{mode: mode_r, size_x: size_x_r, size_y: size_y_r, size_z: size_z_r,
                 cplx: cplx_r, wr: wr};

endmodule

`default_nettype wire

// ----- rtl/scg_ctrl.sv -----
`default_nettype none

module scg_ctrl import scg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencing: take an item, size the grid, prepare the column, emit its entries.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_SIZE;
        end
      end
      ST_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.final_entry) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/scg_datapath.sv -----
`default_nettype none

module scg_datapath import scg_pkg::*; #(
  parameter int unsigned MAX_DIM = SCG_MAX_DIM
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cfg_t      cfg,
  input  wire logic      in_restart,
  input  wire ctrl_cmd_t cmd,
  output dp_status_t     status,
  scg_out_if.source      out_ch
);

  localparam int unsigned SIZE_MAX = (1 << SIZE_W) - 1;
  localparam logic [SIZE_W-1:0] CLAMP_V =
    SIZE_W'((MAX_DIM > SIZE_MAX) ? SIZE_MAX : MAX_DIM);

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    return (v == '0) ? SIZE_W'(1) : ((v > CLAMP_V) ? CLAMP_V : v);
  endfunction

  // Walk state.
  logic [SIZE_W-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [COL_W-1:0]  col_r;
  logic [PTR_W-1:0]  ptr_r;

  // Per-column working registers.
  logic              restart_r;
  mode_t             mode_r;
  logic [SIZE_W-1:0] nx_r, ny_r, nz_r;
  logic [PROD_W-1:0] nxy_r;
  logic [SLOTS-1:0]  rem_r, rem_nxt;
  logic signed [VAL_W-1:0] diag_r;
  logic [COL_W-1:0]  basez_r;
  logic [PTR_W-1:0]  start_r;
  logic              last_r;

  // Output stage.
  logic                    out_valid_r;
  logic [COL_W-1:0]        o_col_r, o_row_r;
  logic signed [VAL_W-1:0] o_re_r;
  logic [IMAG_W-1:0]       o_im_r;
  logic [PTR_W-1:0]        o_start_r;
  logic                    o_cdone_r, o_mdone_r;

  mode_t             mode_c;
  logic [SIZE_W-1:0] nx_c, ny_c, nz_c;
  logic              off_grid;
  logic              bx, by, bz, xl, xg, yl, yg, zl;
  logic              m_ext, m_x3d;
  logic [SLOTS-1:0]  mask_c;
  logic [SLOTS-1:0]  pick;
  logic [SLOT_W-1:0] slot;
  slot_t             si;
  logic [COL_W-1:0]  row_c, yoff, xoff;
  logic              final_entry;

  // Effective mode and grid size from the registers.
  always_comb begin
    unique case (cfg.mode)
      MODE_2D:  mode_c = MODE_2D;
      MODE_3D:  mode_c = MODE_3D;
      MODE_X2D: mode_c = MODE_X2D;
      MODE_X3D: mode_c = MODE_X3D;
      default:  mode_c = MODE_1D;
    endcase
    nx_c = clamp_size(cfg.size_x);
    ny_c = (mode_c == MODE_1D) ? SIZE_W'(1) : clamp_size(cfg.size_y);
    nz_c = (mode_c == MODE_3D || mode_c == MODE_X3D) ? clamp_size(cfg.size_z) : SIZE_W'(1);
  end

  assign off_grid = (pos_x_r == '0) || (pos_x_r > nx_c) || (pos_y_r == '0) ||
                    (pos_y_r > ny_c) || (pos_z_r == '0) || (pos_z_r > nz_c);

  // Boundary flags and the set of entries present in this column.
  always_comb begin
    bx    = (pos_x_r == SIZE_W'(1)) || (pos_x_r == nx_r);
    by    = (pos_y_r == SIZE_W'(1)) || (pos_y_r == ny_r);
    bz    = (pos_z_r == SIZE_W'(1)) || (pos_z_r == nz_r);
    xl    = pos_x_r < nx_r;
    xg    = pos_x_r > SIZE_W'(1);
    yl    = pos_y_r < ny_r;
    yg    = pos_y_r > SIZE_W'(1);
    zl    = pos_z_r < nz_r;
    m_ext = (mode_r == MODE_X2D) || (mode_r == MODE_X3D);
    m_x3d = (mode_r == MODE_X3D);
    mask_c     = '0;
    mask_c[0]  = 1'b1;
    mask_c[1]  = xl;
    mask_c[2]  = m_ext && yl && xg;
    mask_c[3]  = (mode_r != MODE_1D) && yl;
    mask_c[4]  = m_ext && yl && xl;
    mask_c[5]  = m_x3d && zl && yg && xg;
    mask_c[6]  = m_x3d && zl && yg;
    mask_c[7]  = m_x3d && zl && yg && xl;
    mask_c[8]  = m_x3d && zl && xg;
    mask_c[9]  = (m_x3d || (mode_r == MODE_3D)) && zl;
    mask_c[10] = m_x3d && zl && xl;
    mask_c[11] = m_x3d && zl && yl && xg;
    mask_c[12] = m_x3d && zl && yl;
    mask_c[13] = m_x3d && zl && yl && xl;
  end

  // Lowest remaining entry and its row.
  always_comb begin
    pick = rem_r & (~rem_r + SLOTS'(1));
    slot = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (pick[i]) slot = slot | SLOT_W'(i);
    end
    rem_nxt     = rem_r & ~pick;
    final_entry = (rem_nxt == '0);
    si          = slot_info(slot);
    case (si.ysel)
      OFF_PLUS:  yoff = COL_W'(nx_r);
      OFF_MINUS: yoff = COL_W'(0) - COL_W'(nx_r);
      default:   yoff = '0;
    endcase
    case (si.xsel)
      OFF_PLUS:  xoff = COL_W'(1);
      OFF_MINUS: xoff = '1;
      default:   xoff = '0;
    endcase
    row_c = (si.zsel ? basez_r : col_r) + yoff + xoff;
  end

  // Walk registers home on reset, register write, restart, off-grid, matrix end.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg.wr || (cmd.size && (restart_r || off_grid))) begin
      pos_x_r <= SIZE_W'(1);
      pos_y_r <= SIZE_W'(1);
      pos_z_r <= SIZE_W'(1);
      col_r   <= COL_W'(1);
      ptr_r   <= PTR_W'(1);
    end else if (cmd.emit) begin
      if (final_entry && last_r) begin
        pos_x_r <= SIZE_W'(1);
        pos_y_r <= SIZE_W'(1);
        pos_z_r <= SIZE_W'(1);
        col_r   <= COL_W'(1);
        ptr_r   <= PTR_W'(1);
      end else begin
        ptr_r <= ptr_r + PTR_W'(1);
        if (final_entry) begin
          col_r <= col_r + COL_W'(1);
          if (pos_x_r == nx_r) begin
            pos_x_r <= SIZE_W'(1);
            if (pos_y_r == ny_r) begin
              pos_y_r <= SIZE_W'(1);
              pos_z_r <= pos_z_r + SIZE_W'(1);
            end else begin
              pos_y_r <= pos_y_r + SIZE_W'(1);
            end
          end else begin
            pos_x_r <= pos_x_r + SIZE_W'(1);
          end
        end
      end
    end
  end

  // Item capture, grid sizing, column preparation and removal of each emitted entry.
  always_ff @(posedge clk) begin
    if (cmd.capture) restart_r <= in_restart;
    if (cmd.size) begin
      mode_r <= mode_c;
      nx_r   <= nx_c;
      ny_r   <= ny_c;
      nz_r   <= nz_c;
      nxy_r  <= PROD_W'(nx_c) * PROD_W'(ny_c);
    end
    if (cmd.prep) begin
      rem_r   <= mask_c;
      diag_r  <= diag_value(mode_r, bx, by, bz);
      basez_r <= col_r + COL_W'(nxy_r);
      start_r <= ptr_r;
      last_r  <= (pos_x_r == nx_r) && (pos_y_r == ny_r) && (pos_z_r == nz_r);
    end else if (cmd.emit) begin
      rem_r <= rem_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_col_r   <= col_r;
      o_row_r   <= row_c;
      o_re_r    <= (slot == SLOT_DIAG) ? diag_r : si.val;
      o_im_r    <= ((slot == SLOT_EAST) && (mode_r == MODE_1D) && cfg.cplx) ? IMAG_CPLX : '0;
      o_start_r <= start_r;
      o_cdone_r <= final_entry;
      o_mdone_r <= last_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.column_index = o_col_r;
  assign out_ch.row_index    = o_row_r;
  assign out_ch.value_real   = o_re_r;
  assign out_ch.value_imag   = o_im_r;
  assign out_ch.column_start = o_start_r;
  assign out_ch.column_done  = o_cdone_r;
  assign out_ch.matrix_done  = o_mdone_r;

  assign status.out_free    = !out_valid_r || out_ch.ready;
  assign status.final_entry = final_entry;

  // Grid positions are one-based and never reach zero.
  a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_x_r != '0) && (pos_y_r != '0) && (pos_z_r != '0))
    else $error("grid position reached zero");

  // An entry is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten");

  // Every prepared column starts with its diagonal.
  a_diag_first: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.prep |=> rem_r[SLOT_DIAG])
    else $error("column prepared without diagonal");

  // The matrix's last entry sends the walk back to column one.
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && final_entry && last_r) |=> ((col_r == COL_W'(1)) && (ptr_r == PTR_W'(1))))
    else $error("walk did not wrap after last column");

endmodule

`default_nettype wire
